FILE: src/hso_pkg.sv
// Shared constants and the hex font for the status overlay pixel generator.
// Used by hex_status_overlay_pixel; depends on nothing.

package hso_pkg;

    localparam int ROW_COUNT  = 4;
    localparam int MAX_DIGITS = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_TRAP_STATUS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_COUNTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAP_OPCODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT     = 3'd3;

    localparam logic [2:0] COLOR_BACK = 3'd1;
    localparam logic [2:0] COLOR_TEXT = 3'd7;

    localparam logic [8:0] ROW_LEFT = 9'd16;

    localparam logic [7:0] ROW_TOP [ROW_COUNT] = '{8'd20, 8'd70, 8'd120, 8'd170};
    localparam logic [2:0] ROW_DIGITS [ROW_COUNT] = '{3'd2, 3'd6, 3'd2, 3'd4};

    // one 8-pixel row of an upper-case hex glyph, MSB is the leftmost pixel
    function automatic logic [7:0] glyph_row(input logic [3:0] nib, input logic [2:0] row);
        logic [63:0] g;
        case (nib)
            4'h0:    g = 64'h3C666E7666663C00;
            4'h1:    g = 64'h1838181818187E00;
            4'h2:    g = 64'h3C66060C30607E00;
            4'h3:    g = 64'h3C66061C06663C00;
            4'h4:    g = 64'h0C1C3C6C7E0C0C00;
            4'h5:    g = 64'h7E607C0606663C00;
            4'h6:    g = 64'h1C30607C66663C00;
            4'h7:    g = 64'h7E060C1830303000;
            4'h8:    g = 64'h3C66663C66663C00;
            4'h9:    g = 64'h3C66663E060C3800;
            4'hA:    g = 64'h183C66667E666600;
            4'hB:    g = 64'h7C66667C66667C00;
            4'hC:    g = 64'h3C66606060663C00;
            4'hD:    g = 64'h786C6666666C7800;
            4'hE:    g = 64'h7E60607C60607E00;
            4'hF:    g = 64'h7E60607C60606000;
            default: g = 64'h0;
        endcase
        return g[{3'd7 - row, 3'b000} +: 8];
    endfunction

endpackage

FILE: src/hex_status_overlay_pixel.sv
// Status overlay pixel generator: maps a pixel coordinate to a palette index.
// An accepted coordinate beat goes to the input register, its result beat to the
// result register. Throughput: one beat per cycle while m_tready stays high; one
// compute stage sits between them; the result register moves when free or drained.
// Reset (aresetn low, synchronous) empties both stages and clears all four
// displayed registers to zero.
// Depends on hso_pkg.

module hex_status_overlay_pixel #(
    parameter int GLYPH_SCALE   = 3,
    parameter int SCREEN_COLS   = 320,
    parameter int SCREEN_ROWS   = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // [8:0] pixel_x, [16:9] pixel_y, rest zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [2:0] color_index, rest zero

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hso_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hso_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int PITCH  = 9 * GLYPH_SCALE;
    localparam int GLYPH_SPAN = 8 * GLYPH_SCALE;

    logic [7:0]  trap_status_reg;
    logic [23:0] program_counter_reg;
    logic [7:0]  trap_opcode_reg;
    logic [15:0] frame_count_reg;

    logic        in_valid_reg, in_valid_next;
    logic [8:0]  px_reg;
    logic [7:0]  py_reg;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  color_reg;

    logic        advance;

    // compute stage
    logic        on_screen;
    logic        row_hit;
    logic [1:0]  row_sel;
    logic [7:0]  dy;
    logic [8:0]  dx;
    logic [2:0]  digit;
    logic [8:0]  col_off;
    logic [2:0]  gl_row;
    logic [2:0]  gl_col;
    logic [2:0]  row_digits;
    logic [2:0]  nib_idx;
    logic [23:0] row_value;
    logic [3:0]  nib;
    logic [7:0]  glyph_bits;
    logic        lit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trap_status_reg     <= '0;
            program_counter_reg <= '0;
            trap_opcode_reg     <= '0;
            frame_count_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                hso_pkg::CFG_TRAP_STATUS:     trap_status_reg     <= cfg_data[7:0];
                hso_pkg::CFG_PROGRAM_COUNTER: program_counter_reg <= cfg_data[23:0];
                hso_pkg::CFG_TRAP_OPCODE:     trap_opcode_reg     <= cfg_data[7:0];
                hso_pkg::CFG_FRAME_COUNT:     frame_count_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // both stages move when the result slot is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance) out_valid_next = in_valid_reg;
        if (s_tready) in_valid_next = s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            px_reg <= s_tdata[8:0];
            py_reg <= s_tdata[16:9];
        end
        if (advance && in_valid_reg) begin
            color_reg <= lit ? hso_pkg::COLOR_TEXT : hso_pkg::COLOR_BACK;
        end
    end

    always_comb begin
        on_screen = ({1'b0, px_reg} < 10'(SCREEN_COLS)) &&
                    ({2'b00, py_reg} < 10'(SCREEN_ROWS));

        // which text band the row falls in; bands never overlap
        row_hit = 1'b0;
        row_sel = '0;
        for (int r = 0; r < hso_pkg::ROW_COUNT; r++) begin
            if ({1'b0, py_reg} >= {1'b0, hso_pkg::ROW_TOP[r]} &&
                {1'b0, py_reg} < {1'b0, hso_pkg::ROW_TOP[r]} + 9'(GLYPH_SPAN)) begin
                row_hit = 1'b1;
                row_sel = 2'(r);
            end
        end
        dy = py_reg - hso_pkg::ROW_TOP[row_sel];
        dx = px_reg - hso_pkg::ROW_LEFT;

        // digit slot and offset inside it, by threshold compares on the pitch
        digit   = '0;
        col_off = dx;
        for (int k = 1; k <= hso_pkg::MAX_DIGITS; k++) begin
            if (dx >= 9'(k * PITCH)) begin
                digit   = 3'(k);
                col_off = dx - 9'(k * PITCH);
            end
        end

        // unscale glyph row and column
        gl_row = '0;
        gl_col = '0;
        for (int k = 1; k < 8; k++) begin
            if (dy >= 8'(k * GLYPH_SCALE)) gl_row = 3'(k);
            if (col_off >= 9'(k * GLYPH_SCALE)) gl_col = 3'(k);
        end

        row_digits = hso_pkg::ROW_DIGITS[row_sel];
        case (row_sel)
            2'd0:    row_value = {16'h0, trap_status_reg};
            2'd1:    row_value = program_counter_reg;
            2'd2:    row_value = {16'h0, trap_opcode_reg};
            default: row_value = {8'h0, frame_count_reg};
        endcase

        // most significant nibble is drawn first
        nib_idx    = row_digits - 3'd1 - digit;
        nib        = row_value[{nib_idx, 2'b00} +: 4];
        glyph_bits = hso_pkg::glyph_row(nib, gl_row);

        lit = on_screen && row_hit && (px_reg >= hso_pkg::ROW_LEFT) &&
              (digit < row_digits) && (col_off < 9'(GLYPH_SPAN)) &&
              glyph_bits[3'd7 - gl_col];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, color_reg};

    a_color_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] == hso_pkg::COLOR_TEXT ||
                      m_tdata[2:0] == hso_pkg::COLOR_BACK))
        else $error("result is neither text nor backdrop");

    a_lit_in_text_area: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && lit) |-> (px_reg >= hso_pkg::ROW_LEFT && on_screen && row_hit))
        else $error("pixel lit outside the text area");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("compute stage failed to reach the result register");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a downstream stall");

endmodule
